@@ hdl/glmf_pkg.sv @@
// Package for the GNSS log message filter.
// Field widths, command, format and register codes, flag bits and shared types.
// No dependencies.
package glmf_pkg;

  localparam int WEEK_W     = 16;
  localparam int MS_W       = 32;
  localparam int TS_W       = 8;
  localparam int ID_W       = 16;
  localparam int FMT_W      = 4;
  localparam int SRC_W      = 2;
  localparam int CMD_W      = 2;
  localparam int FLAGS_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int STATUS_SLOTS_DEF = 8;
  localparam int ID_SLOTS_DEF     = 16;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [CMD_W-1:0] CMD_FILTER     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_STATUS = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ADD_ID     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 2'd3;

  localparam logic [FMT_W-1:0] FMT_UNKNOWN = 4'd0;
  localparam logic [FMT_W-1:0] FMT_NMEA    = 4'd1;
  localparam logic [FMT_W-1:0] FMT_ALL     = 4'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LOWER_WEEK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_MS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_WEEK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_MS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEC_PERIOD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLAGS      = 3'd5;

  localparam int F_LOWER_ON   = 0;
  localparam int F_UPPER_ON   = 1;
  localparam int F_INV_TIME   = 2;
  localparam int F_DECIMATE   = 3;
  localparam int F_INV_DEC    = 4;
  localparam int F_INV_STATUS = 5;
  localparam int F_INV_ID     = 6;
  localparam int F_KEEP_NMEA  = 7;

  typedef struct packed {
    logic [WEEK_W-1:0]  lower_week;
    logic [MS_W-1:0]    lower_ms;
    logic [WEEK_W-1:0]  upper_week;
    logic [MS_W-1:0]    upper_ms;
    logic [MS_W-1:0]    dec_period;
    logic [FLAGS_W-1:0] flags;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             direct;
    logic             direct_keep;
    logic [MS_W-1:0]  ms;
    logic [TS_W-1:0]  ts;
    logic [ID_W-1:0]  id;
    logic [FMT_W-1:0] fmt;
    logic [SRC_W-1:0] src;
  } q_item_t;

endpackage

@@ hdl/glmf_front.sv @@
// Front end of the log message filter: classifies each input transaction.
// Applies the format rules and the time window, and builds a queue item.
// Depends on glmf_pkg.
module glmf_front (
  input  glmf_pkg::cfg_t                cfg,
  input  logic [glmf_pkg::CMD_W-1:0]    in_command,
  input  logic [glmf_pkg::WEEK_W-1:0]   in_week,
  input  logic [glmf_pkg::MS_W-1:0]     in_milliseconds,
  input  logic [glmf_pkg::TS_W-1:0]     in_time_status,
  input  logic [glmf_pkg::ID_W-1:0]     in_message_id,
  input  logic [glmf_pkg::FMT_W-1:0]    in_format,
  input  logic [glmf_pkg::SRC_W-1:0]    in_source,
  output glmf_pkg::q_item_t             item
);

  logic [glmf_pkg::WEEK_W+glmf_pkg::MS_W-1:0] msg_t, lo_t, hi_t;
  logic lo_on, hi_on, ge_lo, le_hi, time_ok, is_nmea, is_unknown;

  assign msg_t = {in_week, in_milliseconds};
  assign lo_t  = {cfg.lower_week, cfg.lower_ms};
  assign hi_t  = {cfg.upper_week, cfg.upper_ms};
  assign lo_on = cfg.flags[glmf_pkg::F_LOWER_ON];
  assign hi_on = cfg.flags[glmf_pkg::F_UPPER_ON];
  assign ge_lo = (msg_t >= lo_t);
  assign le_hi = (msg_t <= hi_t);

  always_comb begin
    if (cfg.flags[glmf_pkg::F_INV_TIME]) begin
      if (lo_on && hi_on) begin
        time_ok = !(ge_lo && le_hi);
      end else begin
        time_ok = !((ge_lo && lo_on) || (le_hi && hi_on));
      end
    end else begin
      time_ok = !((lo_on && !ge_lo) || (hi_on && !le_hi));
    end
  end

  assign is_nmea    = (in_format == glmf_pkg::FMT_NMEA);
  assign is_unknown = (in_format == glmf_pkg::FMT_UNKNOWN);

  always_comb begin
    item.cmd         = in_command;
    item.direct      = is_unknown || is_nmea || !time_ok;
    item.direct_keep = is_nmea && cfg.flags[glmf_pkg::F_KEEP_NMEA];
    item.ms          = in_milliseconds;
    item.ts          = in_time_status;
    item.id          = in_message_id;
    item.fmt         = in_format;
    item.src         = in_source;
  end

endmodule

@@ hdl/glmf_fifo.sv @@
// Short queue between the front end and the back end of the message filter.
// Holds classified items so each side stalls on its own.
// Depends on glmf_pkg.
module glmf_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  glmf_pkg::q_item_t  wr_item,
  output logic               rd_valid,
  input  logic               rd_pop,
  output glmf_pkg::q_item_t  rd_item
);

  localparam int DEPTH = glmf_pkg::QUEUE_DEPTH;
  localparam int PA_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [PA_W-1:0]  LAST_PTR = PA_W'(DEPTH - 1);

  glmf_pkg::q_item_t mem_r [DEPTH];
  logic [PA_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              push, pop;

  assign wr_ready = (cnt_r != FULL_CNT);
  assign rd_valid = (cnt_r != '0);
  assign rd_item  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ hdl/glmf_mod.sv @@
// Bit-serial remainder unit for the decimation test of the message filter.
// One restoring step per cycle; flags whether the remainder is nonzero.
// Depends on glmf_pkg.
module glmf_mod (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [glmf_pkg::MS_W-1:0] dividend,
  input  logic [glmf_pkg::MS_W-1:0] divisor,
  output logic                      busy,
  output logic                      done,
  output logic                      rem_nz
);

  localparam int W     = glmf_pkg::MS_W;
  localparam int BC_W  = $clog2(W);
  localparam logic [BC_W-1:0] LAST_BIT = BC_W'(W - 1);

  logic            busy_r, done_r;
  logic [BC_W-1:0] bit_r;
  logic [W-1:0]    dvd_r, dsr_r, rem_r;
  logic [W:0]      trial;
  logic [W:0]      diff;

  assign trial  = {rem_r, dvd_r[W-1]};
  assign diff   = trial - {1'b0, dsr_r};
  assign busy   = busy_r;
  assign done   = done_r;
  assign rem_nz = (rem_r != '0);

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[W-2:0], 1'b0};
      rem_r <= diff[W] ? trial[W-1:0] : diff[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      bit_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        bit_r  <= '0;
      end else if (busy_r) begin
        bit_r <= bit_r + 1'b1;
        if (bit_r == LAST_BIT) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/glmf_back.sv @@
// Back end of the message filter: table loads and clears, table scans,
// decimation and the result register. Depends on glmf_pkg and glmf_mod.
module glmf_back #(
  parameter int STATUS_SLOTS = glmf_pkg::STATUS_SLOTS_DEF,
  parameter int ID_SLOTS     = glmf_pkg::ID_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  glmf_pkg::cfg_t     cfg,
  input  logic               q_valid,
  input  glmf_pkg::q_item_t  q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_keep,
  output logic               out_table_full
);

  localparam int SA_W = (STATUS_SLOTS > 1) ? $clog2(STATUS_SLOTS) : 1;
  localparam int SC_W = $clog2(STATUS_SLOTS + 1);
  localparam int IA_W = (ID_SLOTS > 1) ? $clog2(ID_SLOTS) : 1;
  localparam int IC_W = $clog2(ID_SLOTS + 1);
  localparam int ENT_W = glmf_pkg::ID_W + glmf_pkg::FMT_W + glmf_pkg::SRC_W;
  localparam logic [SC_W-1:0] ST_MAX = SC_W'(STATUS_SLOTS);
  localparam logic [IC_W-1:0] ID_MAX = IC_W'(ID_SLOTS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ST   = 2'd1;
  localparam logic [1:0] S_ID   = 2'd2;
  localparam logic [1:0] S_DEC  = 2'd3;

  logic [glmf_pkg::TS_W-1:0] st_mem [STATUS_SLOTS];
  logic [ENT_W-1:0]          id_mem [ID_SLOTS];

  logic [1:0]                state_r, state_nxt;
  glmf_pkg::q_item_t         item_r, item_nxt;
  logic [SC_W-1:0]           st_cnt_r, st_cnt_nxt, st_idx_r, st_idx_nxt;
  logic [IC_W-1:0]           id_cnt_r, id_cnt_nxt, id_idx_r, id_idx_nxt;
  logic                      rv_r, rv_nxt, found_r, found_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_keep_r, out_keep_nxt, out_full_r, out_full_nxt;
  logic [glmf_pkg::TS_W-1:0] st_rd_r;
  logic [ENT_W-1:0]          id_rd_r;
  logic                      st_we, id_we, mod_start, mod_busy, mod_done, mod_rem_nz;
  logic [glmf_pkg::ID_W-1:0]  e_id;
  logic [glmf_pkg::FMT_W-1:0] e_fmt;
  logic [glmf_pkg::SRC_W-1:0] e_src;
  logic                       id_hit;

  assign out_valid      = out_valid_r;
  assign out_keep       = out_keep_r;
  assign out_table_full = out_full_r;

  assign {e_id, e_fmt, e_src} = id_rd_r;
  assign id_hit = (e_id == item_r.id) && (e_src == item_r.src) &&
                  ((e_fmt == glmf_pkg::FMT_ALL) || (e_fmt == item_r.fmt));

  glmf_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (item_r.ms),
    .divisor  (cfg.dec_period),
    .busy     (mod_busy),
    .done     (mod_done),
    .rem_nz   (mod_rem_nz)
  );

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_cnt_r[SA_W-1:0]] <= q_item.ts;
    end
    st_rd_r <= st_mem[st_idx_r[SA_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (id_we) begin
      id_mem[id_cnt_r[IA_W-1:0]] <= {q_item.id, q_item.fmt, q_item.src};
    end
    id_rd_r <= id_mem[id_idx_r[IA_W-1:0]];
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    st_cnt_nxt    = st_cnt_r;
    id_cnt_nxt    = id_cnt_r;
    st_idx_nxt    = st_idx_r;
    id_idx_nxt    = id_idx_r;
    rv_nxt        = rv_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r;
    out_keep_nxt  = out_keep_r;
    out_full_nxt  = out_full_r;
    q_pop         = 1'b0;
    st_we         = 1'b0;
    id_we         = 1'b0;
    mod_start     = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (q_valid && !out_valid_r) begin
          q_pop    = 1'b1;
          item_nxt = q_item;
          unique case (q_item.cmd)
            glmf_pkg::CMD_FILTER: begin
              if (q_item.direct) begin
                out_valid_nxt = 1'b1;
                out_keep_nxt  = q_item.direct_keep;
                out_full_nxt  = 1'b0;
              end else begin
                st_idx_nxt = '0;
                rv_nxt     = 1'b0;
                found_nxt  = 1'b0;
                state_nxt  = S_ST;
              end
            end
            glmf_pkg::CMD_ADD_STATUS: begin
              out_valid_nxt = 1'b1;
              out_keep_nxt  = 1'b0;
              out_full_nxt  = (st_cnt_r >= ST_MAX);
              if (st_cnt_r < ST_MAX) begin
                st_we      = 1'b1;
                st_cnt_nxt = st_cnt_r + 1'b1;
              end
            end
            glmf_pkg::CMD_ADD_ID: begin
              out_valid_nxt = 1'b1;
              out_keep_nxt  = 1'b0;
              out_full_nxt  = (id_cnt_r >= ID_MAX);
              if (id_cnt_r < ID_MAX) begin
                id_we      = 1'b1;
                id_cnt_nxt = id_cnt_r + 1'b1;
              end
            end
            glmf_pkg::CMD_CLEAR: begin
              out_valid_nxt = 1'b1;
              out_keep_nxt  = 1'b0;
              out_full_nxt  = 1'b0;
              st_cnt_nxt    = '0;
              id_cnt_nxt    = '0;
            end
            default: ;
          endcase
        end
      end
      S_ST: begin
        if (st_idx_r < st_cnt_r) begin
          st_idx_nxt = st_idx_r + 1'b1;
          rv_nxt     = 1'b1;
        end else begin
          rv_nxt = 1'b0;
        end
        if (rv_r && (st_rd_r == item_r.ts)) begin
          found_nxt = 1'b1;
        end
        if ((st_idx_r == st_cnt_r) && !rv_r) begin
          if ((st_cnt_r != '0) && (cfg.flags[glmf_pkg::F_INV_STATUS] == found_r)) begin
            out_valid_nxt = 1'b1;
            out_keep_nxt  = 1'b0;
            out_full_nxt  = 1'b0;
            state_nxt     = S_IDLE;
          end else begin
            id_idx_nxt = '0;
            found_nxt  = 1'b0;
            state_nxt  = S_ID;
          end
        end
      end
      S_ID: begin
        if (id_idx_r < id_cnt_r) begin
          id_idx_nxt = id_idx_r + 1'b1;
          rv_nxt     = 1'b1;
        end else begin
          rv_nxt = 1'b0;
        end
        if (rv_r && id_hit) begin
          found_nxt = 1'b1;
        end
        if ((id_idx_r == id_cnt_r) && !rv_r) begin
          if ((id_cnt_r != '0) && (cfg.flags[glmf_pkg::F_INV_ID] == found_r)) begin
            out_valid_nxt = 1'b1;
            out_keep_nxt  = 1'b0;
            out_full_nxt  = 1'b0;
            state_nxt     = S_IDLE;
          end else if (!cfg.flags[glmf_pkg::F_DECIMATE]) begin
            out_valid_nxt = 1'b1;
            out_keep_nxt  = 1'b1;
            out_full_nxt  = 1'b0;
            state_nxt     = S_IDLE;
          end else if (cfg.dec_period == '0) begin
            out_valid_nxt = 1'b1;
            out_keep_nxt  = !cfg.flags[glmf_pkg::F_INV_DEC];
            out_full_nxt  = 1'b0;
            state_nxt     = S_IDLE;
          end else begin
            mod_start = 1'b1;
            state_nxt = S_DEC;
          end
        end
      end
      S_DEC: begin
        if (mod_done) begin
          out_valid_nxt = 1'b1;
          out_keep_nxt  = (cfg.flags[glmf_pkg::F_INV_DEC] == mod_rem_nz);
          out_full_nxt  = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    st_idx_r   <= st_idx_nxt;
    id_idx_r   <= id_idx_nxt;
    found_r    <= found_nxt;
    out_keep_r <= out_keep_nxt;
    out_full_r <= out_full_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      st_cnt_r    <= '0;
      id_cnt_r    <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      st_cnt_r    <= st_cnt_nxt;
      id_cnt_r    <= id_cnt_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_pop_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!out_valid_r && (state_r == S_IDLE)))
    else $error("queue popped while result register busy");
  a_st_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    st_cnt_r <= ST_MAX)
    else $error("status count exceeds table size");
  a_id_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    id_cnt_r <= ID_MAX)
    else $error("id count exceeds table size");
  a_cmd_result: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && (q_item.cmd != glmf_pkg::CMD_FILTER)) |=> (out_valid_r && !out_keep_r))
    else $error("table command did not give an immediate drop result");
  a_dec_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEC) |-> (mod_busy || mod_done))
    else $error("waiting on an idle remainder unit");
`endif

endmodule

@@ hdl/gnss_log_message_filter.sv @@
// GNSS log message filter: one keep/table_full result per input transaction.
// When the format or the time window decides a result, and for loads and
// clears, it is set in the result register as the back end pops the
// transaction from the queue, with no table scan. A message that runs every
// test goes through the status scan, the id scan and the serial remainder for
// decimation; each scan reads one entry per cycle, set by the single read
// port of each table. The back end takes the next queued transaction in the
// cycle after a result is taken. A two-entry queue after the classifier keeps
// accepting transactions, until it is full, while the back end works.
// Depends on glmf_pkg, glmf_front, glmf_fifo and glmf_back.
module gnss_log_message_filter #(
  parameter int STATUS_SLOTS = glmf_pkg::STATUS_SLOTS_DEF,
  parameter int ID_SLOTS     = glmf_pkg::ID_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [glmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [glmf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [glmf_pkg::CMD_W-1:0]     in_command,
  input  logic [glmf_pkg::WEEK_W-1:0]    in_week,
  input  logic [glmf_pkg::MS_W-1:0]      in_milliseconds,
  input  logic [glmf_pkg::TS_W-1:0]      in_time_status,
  input  logic [glmf_pkg::ID_W-1:0]      in_message_id,
  input  logic [glmf_pkg::FMT_W-1:0]     in_format,
  input  logic [glmf_pkg::SRC_W-1:0]     in_source,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_keep,
  output logic                           out_table_full
);

  glmf_pkg::cfg_t    cfg_r;
  glmf_pkg::q_item_t front_item, q_item;
  logic              q_valid, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        glmf_pkg::REG_LOWER_WEEK: cfg_r.lower_week <= cfg_data[glmf_pkg::WEEK_W-1:0];
        glmf_pkg::REG_LOWER_MS:   cfg_r.lower_ms   <= cfg_data[glmf_pkg::MS_W-1:0];
        glmf_pkg::REG_UPPER_WEEK: cfg_r.upper_week <= cfg_data[glmf_pkg::WEEK_W-1:0];
        glmf_pkg::REG_UPPER_MS:   cfg_r.upper_ms   <= cfg_data[glmf_pkg::MS_W-1:0];
        glmf_pkg::REG_DEC_PERIOD: cfg_r.dec_period <= cfg_data[glmf_pkg::MS_W-1:0];
        glmf_pkg::REG_FLAGS:      cfg_r.flags      <= cfg_data[glmf_pkg::FLAGS_W-1:0];
        default: ;
      endcase
    end
  end

  glmf_front u_front (
    .cfg             (cfg_r),
    .in_command      (in_command),
    .in_week         (in_week),
    .in_milliseconds (in_milliseconds),
    .in_time_status  (in_time_status),
    .in_message_id   (in_message_id),
    .in_format       (in_format),
    .in_source       (in_source),
    .item            (front_item)
  );

  glmf_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_valid),
    .wr_ready (in_ready),
    .wr_item  (front_item),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_item  (q_item)
  );

  glmf_back #(
    .STATUS_SLOTS (STATUS_SLOTS),
    .ID_SLOTS     (ID_SLOTS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_keep       (out_keep),
    .out_table_full (out_table_full)
  );

endmodule
